// File: rtl/core/amm_pkg.sv
`timescale 1ns / 1ps
// amm_pkg: shared constants and widths for the swap quote pipeline
// no dependencies

package amm_pkg;

  localparam int unsigned POOL_LANES = 4;
  localparam int unsigned LANE_SLOTS = 4;
  localparam int unsigned FEE_NUM    = 997;
  localparam int unsigned FEE_DEN    = 1000;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned PROD_W = 128;
  localparam int unsigned NUM_W  = 138;
  localparam int unsigned DEN_W  = 75;

  localparam int unsigned DIV_STG    = VAL_W;
  localparam int unsigned PIPE_DEPTH = 3 + DIV_STG;

endpackage

// File: rtl/core/amm_if.sv
`timescale 1ns / 1ps
// amm_in_if / amm_out_if: valid/ready channels for quote requests and results
// depends on nothing

interface amm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] swap_amt;
  logic [63:0] reserve_in_pool0;
  logic [63:0] reserve_in_pool1;
  logic [63:0] reserve_in_pool2;
  logic [63:0] reserve_in_pool3;
  logic [63:0] reserve_out_pool0;
  logic [63:0] reserve_out_pool1;
  logic [63:0] reserve_out_pool2;
  logic [63:0] reserve_out_pool3;

  modport source (output valid, swap_amt, reserve_in_pool0, reserve_in_pool1,
                  reserve_in_pool2, reserve_in_pool3, reserve_out_pool0,
                  reserve_out_pool1, reserve_out_pool2, reserve_out_pool3,
                  input ready);
  modport sink (input valid, swap_amt, reserve_in_pool0, reserve_in_pool1,
                reserve_in_pool2, reserve_in_pool3, reserve_out_pool0,
                reserve_out_pool1, reserve_out_pool2, reserve_out_pool3,
                output ready);
endinterface

interface amm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] amount_out_pool0;
  logic [63:0] amount_out_pool1;
  logic [63:0] amount_out_pool2;
  logic [63:0] amount_out_pool3;

  modport source (output valid, amount_out_pool0, amount_out_pool1,
                  amount_out_pool2, amount_out_pool3, input ready);
  modport sink (input valid, amount_out_pool0, amount_out_pool1,
                amount_out_pool2, amount_out_pool3, output ready);
endinterface

// File: rtl/core/amm_swap_output_quad.sv
`timescale 1ns / 1ps
// amm_swap_output_quad: constant-product swap quotes with 0.3% fee, four pools
// depends on amm_pkg and amm_if
//
// usage
//   in_ch carries one amount and the input/output reserves of four pools;
//   out_ch returns floor(a*997*r_out / (r_in*1000 + a*997)) per pool,
//   or 0 for a pool with an empty reserve. one result transaction per input.
// pipeline
//   one stage of 32x32 partial products, one summing stage, one fee scaling
//   stage, then one restoring divide stage per quotient bit (64), each a
//   76-bit compare and subtract. the last divide stage is the output register.
// throughput
//   one transaction per cycle while out_ch is not stalling;
//   every stage of the four lanes advances together.
// reset
//   rst_n clears all stage valid bits; the pipeline comes up empty.
// stall
//   when out_ch.valid is high and out_ch.ready low the whole pipeline holds
//   and in_ch.ready drops; nothing is lost or repeated.

module amm_swap_output_quad (
  input  logic       clk,
  input  logic       rst_n,
  amm_in_if.sink     in_ch,
  amm_out_if.source  out_ch
);

  localparam int unsigned NL = amm_pkg::LANE_SLOTS;
  localparam int unsigned NS = amm_pkg::DIV_STG;
  localparam int unsigned ND = amm_pkg::PIPE_DEPTH;
  localparam int unsigned VW = amm_pkg::VAL_W;
  localparam int unsigned DW = amm_pkg::DEN_W;

  logic          advance;
  logic [ND-1:0] v_r;

  logic [VW-1:0] rin_w  [NL];
  logic [VW-1:0] rout_w [NL];
  logic [VW-1:0] res_w  [NL];

  logic [VW-1:0] pp0_r [NL];
  logic [VW-1:0] pp1_r [NL];
  logic [VW-1:0] pp2_r [NL];
  logic [VW-1:0] pp3_r [NL];
  logic [DW-1:0] den1_r [NL];
  logic          z1_r   [NL];

  logic [amm_pkg::PROD_W-1:0] prod_r [NL];
  logic [DW-1:0]              den2_r [NL];
  logic                       z2_r   [NL];

  logic [DW-1:0] rem_r [NL][NS+1];
  logic [VW-1:0] lo_r  [NL][NS+1];
  logic [VW-1:0] q_r   [NL][NS+1];
  logic [DW-1:0] den_r [NL][NS+1];
  logic          z_r   [NL][NS+1];

  assign advance     = !v_r[ND-1] || out_ch.ready;
  assign in_ch.ready = advance;

  always_comb begin
    rin_w[0]  = in_ch.reserve_in_pool0;
    rin_w[1]  = in_ch.reserve_in_pool1;
    rin_w[2]  = in_ch.reserve_in_pool2;
    rin_w[3]  = in_ch.reserve_in_pool3;
    rout_w[0] = in_ch.reserve_out_pool0;
    rout_w[1] = in_ch.reserve_out_pool1;
    rout_w[2] = in_ch.reserve_out_pool2;
    rout_w[3] = in_ch.reserve_out_pool3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[ND-2:0], in_ch.valid};
    end
  end

  for (genvar ln = 0; ln < NL; ln++) begin : g_lane
    if (ln < amm_pkg::POOL_LANES) begin : g_used
      logic [amm_pkg::NUM_W-1:0] num_w;

      assign num_w = amm_pkg::NUM_W'(prod_r[ln]) *
                     amm_pkg::NUM_W'(amm_pkg::FEE_NUM);

      always_ff @(posedge clk) begin
        if (advance) begin
          pp0_r[ln]  <= VW'(in_ch.swap_amt[31:0]) * VW'(rout_w[ln][31:0]);
          pp1_r[ln]  <= VW'(in_ch.swap_amt[31:0]) * VW'(rout_w[ln][63:32]);
          pp2_r[ln]  <= VW'(in_ch.swap_amt[63:32]) * VW'(rout_w[ln][31:0]);
          pp3_r[ln]  <= VW'(in_ch.swap_amt[63:32]) * VW'(rout_w[ln][63:32]);
          den1_r[ln] <= DW'(rin_w[ln]) * DW'(amm_pkg::FEE_DEN) +
                        DW'(in_ch.swap_amt) * DW'(amm_pkg::FEE_NUM);
          z1_r[ln]   <= (rin_w[ln] == '0) || (rout_w[ln] == '0);

          prod_r[ln] <= {64'd0, pp0_r[ln]} + {32'd0, pp1_r[ln], 32'd0} +
                        {32'd0, pp2_r[ln], 32'd0} + {pp3_r[ln], 64'd0};
          den2_r[ln] <= den1_r[ln];
          z2_r[ln]   <= z1_r[ln];

          rem_r[ln][0] <= {1'b0, num_w[amm_pkg::NUM_W-1:VW]};
          lo_r[ln][0]  <= num_w[VW-1:0];
          q_r[ln][0]   <= '0;
          den_r[ln][0] <= den2_r[ln];
          z_r[ln][0]   <= z2_r[ln];
        end
      end

      for (genvar k = 1; k <= NS; k++) begin : g_div
        logic [DW:0]   t_w;
        logic [DW+1:0] diff_w;
        logic          ge_w;

        assign t_w    = {rem_r[ln][k-1], lo_r[ln][k-1][VW-1]};
        assign diff_w = {1'b0, t_w} - {2'b0, den_r[ln][k-1]};
        assign ge_w   = !diff_w[DW+1];

        always_ff @(posedge clk) begin
          if (advance) begin
            rem_r[ln][k] <= ge_w ? diff_w[DW-1:0] : t_w[DW-1:0];
            lo_r[ln][k]  <= {lo_r[ln][k-1][VW-2:0], 1'b0};
            q_r[ln][k]   <= {q_r[ln][k-1][VW-2:0], ge_w};
            den_r[ln][k] <= den_r[ln][k-1];
            z_r[ln][k]   <= z_r[ln][k-1];
          end
        end
      end

      assign res_w[ln] = z_r[ln][NS] ? '0 : q_r[ln][NS];
    end else begin : g_unused
      assign res_w[ln] = '0;
    end
  end

  assign out_ch.valid            = v_r[ND-1];
  assign out_ch.amount_out_pool0 = res_w[0];
  assign out_ch.amount_out_pool1 = res_w[1];
  assign out_ch.amount_out_pool2 = res_w[2];
  assign out_ch.amount_out_pool3 = res_w[3];

  // a stalled pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(v_r))
    else $error("pipeline valid bits moved during a stall");

  // final partial remainder of pool 0 stays below its divisor when valid and non-empty
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[ND-1] && !z_r[0][NS] |-> rem_r[0][NS] < den_r[0][NS])
    else $error("divider remainder not below divisor");

  // an accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted transaction lost at entry");

endmodule
